>>> rtl/substring_first_index_search_unit_defines.svh
// Assertion helpers; expect signals clk and rst in the using scope.
`ifndef SUBSTRING_FIRST_INDEX_SEARCH_UNIT_DEFINES_SVH
`define SUBSTRING_FIRST_INDEX_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssu_pkg.sv
package ssu_pkg;

  localparam int CHAR_W      = 8;
  localparam int OFFSET_W    = 16;
  localparam int INDEX_OUT_W = 16;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [CHAR_W-1:0]   char_value;
    logic                is_last;
    logic [OFFSET_W-1:0] start_offset;
  } ssu_item_t;

  typedef struct packed {
    logic                   found;
    logic [INDEX_OUT_W-1:0] match_index;
    logic                   pattern_overflow;
  } ssu_result_t;

endpackage

>>> rtl/substring_first_index_search_unit.sv
// Channel  | Signals                                          | Moves
// item     | item_valid, item_stall, operation, char_value,   | one pattern or text byte
//          | is_last, start_offset                            |
// result   | result_valid, result_stall, found, match_index,  | one result per text
//          | pattern_overflow                                 |
// One item per cycle while item_stall is low.
// Path: input register, then window compare and state update into the result register.
// Synchronous reset; the pattern store and text window hold data only and are not cleared.
// item_stall rises only when a last text byte waits behind a stalled result.
module substring_first_index_search_unit import ssu_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   operation,
  input  logic [CHAR_W-1:0]      char_value,
  input  logic                   is_last,
  input  logic [OFFSET_W-1:0]    start_offset,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   found,
  output logic [INDEX_OUT_W-1:0] match_index,
  output logic                   pattern_overflow
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                               s1_valid;
  ssu_item_t                          s1_item;
  logic                               accept;
  logic                               s1_emits;
  logic                               s1_go;
  logic [PATTERN_MAX-1:0][CHAR_W-1:0] pat;
  logic [LEN_W-1:0]                   pat_len;
  logic                               too_long;
  ssu_result_t                        res;

  assign s1_emits   = s1_valid && (s1_item.operation == OP_TEXT) && s1_item.is_last;
  assign item_stall = s1_emits && result_valid && result_stall;
  assign s1_go      = s1_valid && !item_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= '{operation: op_t'(operation), char_value: char_value,
                   is_last: is_last, start_offset: start_offset};
    end
  end

  ssu_pattern #(
    .PATTERN_MAX(PATTERN_MAX),
    .LEN_W      (LEN_W)
  ) u_pattern (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && (s1_item.operation == OP_PATTERN)),
    .char_value(s1_item.char_value),
    .is_last   (s1_item.is_last),
    .pat       (pat),
    .pat_len   (pat_len),
    .too_long  (too_long)
  );

  ssu_match #(
    .PATTERN_MAX(PATTERN_MAX),
    .INDEX_BITS (INDEX_BITS),
    .LEN_W      (LEN_W)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .search      (s1_go && (s1_item.operation == OP_TEXT)),
    .char_value  (s1_item.char_value),
    .is_last     (s1_item.is_last),
    .start_offset(s1_item.start_offset),
    .pat         (pat),
    .pat_len     (pat_len),
    .too_long    (too_long),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_emits) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      found            <= res.found;
      match_index      <= res.match_index;
      pattern_overflow <= res.pattern_overflow;
    end
  end

endmodule

>>> rtl/ssu_pattern.sv
module ssu_pattern import ssu_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [CHAR_W-1:0]                   char_value,
  input  logic                                is_last,
  output logic [PATTERN_MAX-1:0][CHAR_W-1:0]  pat,
  output logic [LEN_W-1:0]                    pat_len,
  output logic                                too_long
);

  // Pattern kept reversed: pat[j] = pattern[pat_len-1-j], so it lines up
  // with the text window (newest byte at entry 0). Appending is a shift.
  logic                               closed;
  logic                               closed_next;
  logic [LEN_W-1:0]                   pat_len_next;
  logic                               too_long_next;
  logic [PATTERN_MAX:0][CHAR_W-1:0]   pat_ext;
  logic [LEN_W-1:0]                   len_base;
  logic                               tl_base;
  logic                               room;

  assign pat_ext  = {pat, char_value};
  assign len_base = closed ? '0 : pat_len;
  assign tl_base  = closed ? 1'b0 : too_long;
  assign room     = len_base < LEN_W'(PATTERN_MAX);

  always_comb begin
    pat_len_next  = pat_len;
    too_long_next = too_long;
    closed_next   = closed;
    if (load) begin
      pat_len_next  = room ? len_base + LEN_W'(1) : len_base;
      too_long_next = tl_base | ~room;
      closed_next   = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len  <= '0;
      too_long <= 1'b0;
      closed   <= 1'b1;
    end else begin
      pat_len  <= pat_len_next;
      too_long <= too_long_next;
      closed   <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      pat <= pat_ext[PATTERN_MAX-1:0];
    end
  end

endmodule

>>> rtl/ssu_match.sv
module ssu_match import ssu_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int INDEX_BITS  = 16,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                search,
  input  logic [CHAR_W-1:0]                   char_value,
  input  logic                                is_last,
  input  logic [OFFSET_W-1:0]                 start_offset,
  input  logic [PATTERN_MAX-1:0][CHAR_W-1:0]  pat,
  input  logic [LEN_W-1:0]                    pat_len,
  input  logic                                too_long,
  output ssu_result_t                         result
);

  localparam int PW = INDEX_BITS + 1;
  localparam int CW = PW + OFFSET_W;

  logic [PATTERN_MAX-1:0][CHAR_W-1:0] window;
  logic [PATTERN_MAX:0][CHAR_W-1:0]   win_ext;
  logic [PATTERN_MAX-1:0][CHAR_W-1:0] win_new;
  logic [PW-1:0]                      pos;
  logic [PW-1:0]                      pos_next;
  logic [OFFSET_W-1:0]                offset;
  logic [OFFSET_W-1:0]                offset_next;
  logic                               seen;
  logic                               seen_next;
  logic [INDEX_BITS-1:0]              first_idx;
  logic [INDEX_BITS-1:0]              first_idx_next;

  logic                  fresh;
  logic [OFFSET_W-1:0]   off_eff;
  logic                  seen_eff;
  logic [INDEX_BITS-1:0] idx_eff;
  logic [PATTERN_MAX-1:0] eq;
  logic [PW-1:0]         count;
  logic [PW-1:0]         start;
  logic                  not_sat;
  logic                  hit;
  logic                  found_now;

  assign win_ext = {window, char_value};
  assign win_new = win_ext[PATTERN_MAX-1:0];

  // Entries past the pattern length compare as equal.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      eq[j] = (win_new[j] == pat[j]) || (LEN_W'(j) >= pat_len);
    end
  end

  assign fresh    = pos == '0;
  assign off_eff  = fresh ? start_offset : offset;
  assign seen_eff = fresh ? 1'b0 : seen;
  assign idx_eff  = fresh ? '0 : first_idx;
  assign not_sat  = pos != '1;
  assign count    = pos + PW'(1);
  assign start    = count - PW'(pat_len);

  assign hit = not_sat && !too_long && !seen_eff && (pat_len != '0) &&
               (count >= PW'(pat_len)) && (CW'(start) >= CW'(off_eff)) &&
               !start[PW-1] && (&eq);

  assign found_now = seen_eff | hit;

  always_comb begin
    pos_next       = pos;
    offset_next    = offset;
    seen_next      = seen;
    first_idx_next = first_idx;
    if (search) begin
      if (is_last) begin
        pos_next       = '0;
        offset_next    = '0;
        seen_next      = 1'b0;
        first_idx_next = '0;
      end else begin
        pos_next       = not_sat ? count : pos;
        offset_next    = off_eff;
        seen_next      = found_now;
        first_idx_next = hit ? start[INDEX_BITS-1:0] : idx_eff;
      end
    end
  end

  always_comb begin
    result = '0;
    if (too_long) begin
      result.pattern_overflow = 1'b1;
    end else if (found_now) begin
      result.found       = 1'b1;
      result.match_index = hit ? INDEX_OUT_W'(start[INDEX_BITS-1:0])
                               : INDEX_OUT_W'(idx_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      offset    <= '0;
      seen      <= 1'b0;
      first_idx <= '0;
    end else begin
      pos       <= pos_next;
      offset    <= offset_next;
      seen      <= seen_next;
      first_idx <= first_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (search) begin
      window <= win_new;
    end
  end

endmodule

>>> rtl/ssu_checker.sv
`include "substring_first_index_search_unit_defines.svh"

module ssu_checker import ssu_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   operation,
  input logic [CHAR_W-1:0]      char_value,
  input logic                   is_last,
  input logic [OFFSET_W-1:0]    start_offset,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic                   found,
  input logic [INDEX_OUT_W-1:0] match_index,
  input logic                   pattern_overflow
);

  // stalled result holds
  `SSU_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(found) && $stable(match_index) && $stable(pattern_overflow), "stalled result changed")

  // not found reports index zero
  `SSU_ASSERT_NOW(a_idx_zero, result_valid && !found, match_index == '0, "index set without a match")

  // an overflowed pattern never matches
  `SSU_ASSERT_NOW(a_ovf_nofound, result_valid && pattern_overflow, !found, "match with overflowed pattern")

  // input backs up only behind a stalled result
  `SSU_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "input stall without output stall")

endmodule

bind substring_first_index_search_unit ssu_checker u_ssu_checker (.*);

>>> sim/tb.sv
module tb;
  import ssu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_MAX = 16;
  localparam logic [16:0] POS_LIMIT = 17'h1FFFF;
  localparam logic [17:0] IDX_LIMIT = 18'h0FFFF;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic                   operation;
  logic [CHAR_W-1:0]      char_value;
  logic                   is_last;
  logic [OFFSET_W-1:0]    start_offset;
  logic                   result_valid;
  logic                   result_stall;
  logic                   found;
  logic [INDEX_OUT_W-1:0] match_index;
  logic                   pattern_overflow;

  substring_first_index_search_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .operation        (operation),
    .char_value       (char_value),
    .is_last          (is_last),
    .start_offset     (start_offset),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .found            (found),
    .match_index      (match_index),
    .pattern_overflow (pattern_overflow)
  );

  // search state mirrored from the block's behavior
  logic [CHAR_W-1:0]   pat_bytes [PAT_MAX];
  logic [4:0]          pat_len;
  logic                pat_closed;
  logic                pat_over;
  logic [CHAR_W-1:0]   win [PAT_MAX];
  logic [16:0]         txt_pos;
  logic [OFFSET_W-1:0] txt_offset;
  logic                hit_seen;
  logic [15:0]         hit_index;

  ssu_result_t pending_results [$];
  int          mismatches;
  int          items_sent;
  int          texts_closed;

  // set by the sender together with the payload
  logic        row_typed;
  ssu_result_t row_expect;

  logic idle_on;
  logic hold_req;

  typedef struct {
    op_t                 op;
    logic [CHAR_W-1:0]   ch;
    logic                last;
    logic [OFFSET_W-1:0] offs;
    int                  rep;
    logic                typed;
    ssu_result_t         res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void clear_text_state();
    for (int k = 0; k < PAT_MAX; k++) win[k] = '0;
    txt_pos    = '0;
    txt_offset = '0;
    hit_seen   = 1'b0;
    hit_index  = '0;
  endfunction

  function automatic void clear_search_model();
    for (int k = 0; k < PAT_MAX; k++) pat_bytes[k] = '0;
    pat_len    = '0;
    pat_closed = 1'b1;
    pat_over   = 1'b0;
    clear_text_state();
  endfunction

  function automatic void step_search_model(input op_t op, input logic [CHAR_W-1:0] ch,
                                            input logic last, input logic [OFFSET_W-1:0] offs,
                                            output logic has_res, output ssu_result_t res);
    logic [17:0] count;
    logic [17:0] start;
    logic        hit;
    has_res = 1'b0;
    res     = '0;
    if (op == OP_PATTERN) begin
      if (pat_closed) begin
        pat_len    = '0;
        pat_over   = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < PAT_MAX) begin
        pat_bytes[pat_len[3:0]] = ch;
        pat_len = pat_len + 5'd1;
      end else begin
        pat_over = 1'b1;
      end
      if (last) pat_closed = 1'b1;
      return;
    end
    if (txt_pos == 0) begin
      txt_offset = offs;
      hit_seen   = 1'b0;
      hit_index  = '0;
    end
    for (int k = PAT_MAX - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = ch;
    // once saturated the position stops and no compare is made
    if (txt_pos < POS_LIMIT) begin
      count = {1'b0, txt_pos} + 18'd1;
      if (!pat_over && !hit_seen && pat_len != 0 && count >= pat_len) begin
        start = count - pat_len;
        hit = (start >= txt_offset) && (start <= IDX_LIMIT);
        for (int k = 0; k < pat_len; k++)
          if (win[pat_len-1-k] != pat_bytes[k]) hit = 1'b0;
        if (hit) begin
          hit_seen  = 1'b1;
          hit_index = start[15:0];
        end
      end
      txt_pos = count[16:0];
    end
    if (last) begin
      has_res = 1'b1;
      res.found            = pat_over ? 1'b0 : hit_seen;
      res.match_index      = (pat_over || !hit_seen) ? '0 : hit_index;
      res.pattern_overflow = pat_over;
      clear_text_state();
    end
  endfunction

  function automatic void add_row(input op_t op, input logic [7:0] ch, input logic last,
                                  input logic [15:0] offs, input int rep, input logic typed,
                                  input logic e_found, input logic [15:0] e_idx,
                                  input logic e_ovf);
    dir_row_t r;
    r.op    = op;
    r.ch    = ch;
    r.last  = last;
    r.offs  = offs;
    r.rep   = rep;
    r.typed = typed;
    r.res.found            = e_found;
    r.res.match_index      = e_idx;
    r.res.pattern_overflow = e_ovf;
    dir_rows.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // input side: every accepted transfer advances the mirrored state
  always @(posedge clk) begin
    logic        has_res;
    ssu_result_t res;
    if (!rst && item_valid && !item_stall) begin
      step_search_model(op_t'(operation), char_value, is_last, start_offset, has_res, res);
      if (has_res) pending_results.push_back(row_typed ? row_expect : res);
    end
  end

  // output side
  always @(posedge clk) begin
    ssu_result_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d index=%0d overflow=%0d",
                   found, match_index, pattern_overflow);
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found || match_index !== exp_res.match_index ||
            pattern_overflow !== exp_res.pattern_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0d index=%0d overflow=%0d, got %0d %0d %0d",
                     exp_res.found, exp_res.match_index, exp_res.pattern_overflow,
                     found, match_index, pattern_overflow);
        end
      end
    end
  end

  // receiver: random hold-off before each transfer while idle_on is set, one long one on request
  initial begin
    int n;
    result_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        n = 300;
        hold_req = 1'b0;
      end else begin
        n = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        result_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] ch, input logic last,
                           input logic [15:0] offs, input logic typed, input ssu_result_t res);
    int n;
    n = idle_on ? $urandom_range(0, 16) : 0;
    if (n > 0) begin
      item_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    operation    = op;
    char_value   = ch;
    is_last      = last;
    start_offset = offs;
    row_typed    = typed;
    row_expect   = res;
    item_valid   = 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (op == OP_TEXT && last) texts_closed++;
    @(negedge clk);
  endtask

  task automatic send_plain(input op_t op, input logic [7:0] ch, input logic last,
                            input logic [15:0] offs);
    send_item(op, ch, last, offs, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_char(input logic narrow);
    return narrow ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int          rand_start;
    int          texts_start;
    int          plen;
    int          tlen;
    int          kind;
    int          w;
    logic        narrow;
    logic [15:0] offs;

    rst          = 1'b1;
    item_valid   = 1'b0;
    operation    = OP_PATTERN;
    char_value   = '0;
    is_last      = 1'b0;
    start_offset = '0;
    row_typed    = 1'b0;
    row_expect   = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    texts_closed = 0;
    clear_search_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // text before any pattern: empty pattern never matches
    add_row(OP_TEXT,    8'h61, 1'b1, 16'h0000,  1, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(OP_PATTERN, 8'h00, 1'b0, 16'hFFFF,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_PATTERN, 8'hFF, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h00, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'hFF, 1'b1, 16'hFFFF,  1, 1'b1, 1'b1, 16'd0, 1'b0);
    // text shorter than the pattern
    add_row(OP_TEXT,    8'hFF, 1'b1, 16'h0000,  1, 1'b1, 1'b0, 16'd0, 1'b0);
    // offset beyond the end of the text
    add_row(OP_TEXT,    8'h00, 1'b0, 16'hFFFF,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'hFF, 1'b1, 16'h0000,  1, 1'b1, 1'b0, 16'd0, 1'b0);
    // offset of one, match found at index one
    add_row(OP_TEXT,    8'h00, 1'b0, 16'h0001,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h00, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'hFF, 1'b1, 16'h0000,  1, 1'b1, 1'b1, 16'd1, 1'b0);
    // 17 pattern bytes overflow the store
    add_row(OP_PATTERN, 8'h78, 1'b0, 16'h0000, 16, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_PATTERN, 8'h79, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h78, 1'b1, 16'h0000,  1, 1'b1, 1'b0, 16'd0, 1'b1);
    // pattern still open while text streams, then appended
    add_row(OP_PATTERN, 8'h71, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h71, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_PATTERN, 8'h72, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h72, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    // new pattern loaded in the middle of a text
    add_row(OP_TEXT,    8'h7A, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_PATTERN, 8'h7A, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h6B, 1'b0, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OP_TEXT,    8'h7A, 1'b1, 16'h0000,  1, 1'b0, 1'b0, 16'd0, 1'b0);

    foreach (dir_rows[i])
      for (int r = 0; r < dir_rows[i].rep; r++)
        send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].last, dir_rows[i].offs,
                  dir_rows[i].typed, dir_rows[i].res);

    // two-byte pattern for the back-to-back texts below
    idle_on = 1'b0;
    send_plain(OP_PATTERN, 8'h41, 1'b0, 16'h0000);
    send_plain(OP_PATTERN, 8'h42, 1'b1, 16'h0000);

    // receiver holds off while short texts keep coming
    hold_req = 1'b1;
    for (int t = 0; t < 20; t++) begin
      send_plain(OP_TEXT, 8'h41, 1'b0, 16'h0000);
      send_plain(OP_TEXT, 8'h42, 1'b1, 16'h0000);
    end

    rand_start  = items_sent;
    texts_start = texts_closed;
    while (items_sent - rand_start < 400 || texts_closed - texts_start < 40) begin
      idle_on = ($urandom_range(0, 3) != 0);
      narrow  = ($urandom_range(0, 4) != 0);
      kind    = $urandom_range(0, 9);
      if (kind == 0) begin
        send_plain(op_t'($urandom_range(0, 1)), pick_char(1'b0), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
      end else begin
        if (kind <= 4) begin
          plen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
          for (int p = 0; p < plen; p++)
            send_plain(OP_PATTERN, pick_char(narrow), p == plen - 1,
                       16'($urandom_range(0, 65535)));
        end
        tlen = $urandom_range(1, 12);
        offs = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, tlen));
        for (int p = 0; p < tlen; p++)
          send_plain(OP_TEXT, pick_char(narrow), p == tlen - 1,
                     (p == 0) ? offs : 16'($urandom_range(0, 65535)));
      end
    end
    item_valid = 1'b0;

    w = 0;
    while (pending_results.size() > 0 && w < 5000) begin
      @(posedge clk);
      w++;
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ssu_pkg.sv
rtl/ssu_pattern.sv
rtl/ssu_match.sv
rtl/substring_first_index_search_unit.sv
rtl/ssu_checker.sv
sim/tb.sv
